[hw/rtl/ibd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibd_pkg
// Shared types, constants and helpers of the idle backlight dimmer.
// ----------------------------------------------------------------------------
package ibd_pkg;

  // field widths
  localparam int LEVEL_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int PCT_BITS   = 7;
  localparam int PCTS_BITS  = 2 * PCT_BITS;
  localparam int FLAG_BITS  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // stream payload widths, padded to whole bytes
  localparam int IN_USED_W  = TIME_BITS + 1 + LEVEL_BITS;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W = LEVEL_BITS + 1 + 3;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // mode flag bit positions
  localparam int FLAG_RELATIVE = 0;
  localparam int FLAG_BAT_EN   = 1;
  localparam int FLAG_AC_EN    = 2;

  // divide by 100 with rounding: floor((p*b + 50) * K / 2^30), exact for
  // every product of a 7-bit percent and a 16-bit level
  localparam int RECIP_W   = 31;
  localparam int DIV_SHIFT = 30;
  localparam logic [RECIP_W-1:0] DIV_K = RECIP_W'(10737419);
  localparam logic [RECIP_W-1:0] ROUND_ADD = RECIP_W'(50 * 10737419);
  localparam int PROD_W    = RECIP_W + LEVEL_BITS + 1;
  localparam int QUOT_W    = LEVEL_BITS + 1;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE_FLAGS  = 3'd0,
    CFG_BAT_DIM     = 3'd1,
    CFG_BAT_OFF     = 3'd2,
    CFG_AC_DIM      = 3'd3,
    CFG_AC_OFF      = 3'd4,
    CFG_BAT_PCTS    = 3'd5,
    CFG_AC_PCTS     = 3'd6,
    CFG_FULL_LEVEL  = 3'd7
  } cfg_idx_e;

  // register reset values
  localparam logic [FLAG_BITS-1:0]  RST_MODE_FLAGS = 3'd2;
  localparam logic [TIME_BITS-1:0]  RST_BAT_DIM    = 32'd3000000;
  localparam logic [TIME_BITS-1:0]  RST_BAT_OFF    = 32'd10000000;
  localparam logic [TIME_BITS-1:0]  RST_AC_DIM     = 32'd5000000;
  localparam logic [TIME_BITS-1:0]  RST_AC_OFF     = 32'd20000000;
  localparam logic [PCTS_BITS-1:0]  RST_BAT_PCTS   = 14'd12850;
  localparam logic [PCTS_BITS-1:0]  RST_AC_PCTS    = 14'd12880;
  localparam logic [LEVEL_BITS-1:0] RST_FULL_LEVEL = 16'd255;

  // display mode
  typedef enum logic [2:0] {
    MODE_BAT_NORMAL = 3'd0,
    MODE_BAT_DIM    = 3'd1,
    MODE_BAT_OFF    = 3'd2,
    MODE_AC_NORMAL  = 3'd3,
    MODE_AC_DIM     = 3'd4,
    MODE_AC_OFF     = 3'd5,
    MODE_NONE       = 3'd7
  } mode_e;

  // configuration register set
  typedef struct packed {
    logic [FLAG_BITS-1:0]  mode_flags;
    logic [TIME_BITS-1:0]  bat_dim;
    logic [TIME_BITS-1:0]  bat_off;
    logic [TIME_BITS-1:0]  ac_dim;
    logic [TIME_BITS-1:0]  ac_off;
    logic [PCTS_BITS-1:0]  bat_pcts;
    logic [PCTS_BITS-1:0]  ac_pcts;
    logic [LEVEL_BITS-1:0] full_level;
  } cfg_t;

  // request from the mode stage to the scaling stage
  typedef struct packed {
    logic                  vld;
    logic                  passthru;
    logic                  blank;
    mode_e                 mode;
    logic [RECIP_W-1:0]    recip;
    logic [LEVEL_BITS-1:0] base;
    logic [LEVEL_BITS-1:0] cap;
  } scale_req_t;

  // percent times the reciprocal of 100, a constant table in effect
  function automatic logic [RECIP_W-1:0] pct_recip(input logic [PCT_BITS-1:0] pct);
    logic [RECIP_W-1:0] p;
    p = {{(RECIP_W - PCT_BITS){1'b0}}, pct};
    pct_recip = RECIP_W'(p * DIV_K);
  endfunction

endpackage

[hw/rtl/ibd_mode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibd_mode
// Mode tracker: classes an idle sample, keeps mode and saved level, and
// picks the percent and base of the level to write.
// ----------------------------------------------------------------------------
module ibd_mode (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           vld_i,
  input  logic [ibd_pkg::TIME_BITS-1:0]  idle_ms_i,
  input  logic                           on_mains_i,
  input  logic [ibd_pkg::LEVEL_BITS-1:0] current_level_i,
  input  ibd_pkg::cfg_t                  cfg_i,
  output ibd_pkg::scale_req_t            req_o
);
  import ibd_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [LEVEL_BITS-1:0] saved_q, saved_d;
  logic                  primed_q;

  logic                  bat_sel, ac_sel, relative;
  logic [TIME_BITS-1:0]  dim_t, off_t;
  logic [PCTS_BITS-1:0]  pcts;
  logic [LEVEL_BITS-1:0] saved_eff;
  logic                  is_norm, is_dim, is_off, hit;
  mode_e                 new_mode;

  // profile and class selection
  always_comb begin
    relative  = cfg_i.mode_flags[FLAG_RELATIVE];
    bat_sel   = !on_mains_i && cfg_i.mode_flags[FLAG_BAT_EN];
    ac_sel    = on_mains_i && cfg_i.mode_flags[FLAG_AC_EN];
    dim_t     = ac_sel ? cfg_i.ac_dim : cfg_i.bat_dim;
    off_t     = ac_sel ? cfg_i.ac_off : cfg_i.bat_off;
    pcts      = ac_sel ? cfg_i.ac_pcts : cfg_i.bat_pcts;
    // first sample loads the saved level
    saved_eff = primed_q ? saved_q : current_level_i;

    is_norm = idle_ms_i < dim_t;
    is_dim  = !is_norm && (idle_ms_i > dim_t) && (idle_ms_i < off_t);
    is_off  = !is_norm && !is_dim && (idle_ms_i > off_t);

    if (is_dim) begin
      new_mode = ac_sel ? MODE_AC_DIM : MODE_BAT_DIM;
    end else if (is_off) begin
      new_mode = ac_sel ? MODE_AC_OFF : MODE_BAT_OFF;
    end else begin
      new_mode = ac_sel ? MODE_AC_NORMAL : MODE_BAT_NORMAL;
    end

    hit = (bat_sel || ac_sel) && (is_norm || is_dim || is_off) && (new_mode != mode_q);
  end

  // scaling request and next state
  always_comb begin
    req_o.vld      = vld_i && hit;
    req_o.passthru = !is_dim && relative;
    req_o.blank    = is_off;
    req_o.mode     = new_mode;
    req_o.recip    = pct_recip(is_dim ? pcts[PCT_BITS-1:0] : pcts[PCTS_BITS-1:PCT_BITS]);
    req_o.cap      = cfg_i.full_level;
    if (is_dim) begin
      req_o.base = relative ? current_level_i : cfg_i.full_level;
    end else begin
      req_o.base = relative ? saved_eff : cfg_i.full_level;
    end

    mode_d  = hit ? new_mode : mode_q;
    saved_d = (hit && is_dim && relative) ? current_level_i : saved_eff;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      saved_q  <= '0;
      primed_q <= 1'b0;
    end else if (step_i && vld_i) begin
      mode_q   <= mode_d;
      saved_q  <= saved_d;
      primed_q <= 1'b1;
    end
  end

endmodule

[hw/rtl/ibd_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibd_scale
// Level scaling: percent of a base level, rounded half up, clamped to the
// panel maximum, or the saved level passed on as it is.
// ----------------------------------------------------------------------------
module ibd_scale (
  input  ibd_pkg::scale_req_t            req_i,
  output logic [ibd_pkg::LEVEL_BITS-1:0] level_o
);
  import ibd_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  // one multiply by the premultiplied reciprocal, then shift
  always_comb begin
    prod = PROD_W'(req_i.recip) * PROD_W'(req_i.base) + PROD_W'(ROUND_ADD);
    quot = prod[DIV_SHIFT +: QUOT_W];
    if (req_i.passthru) begin
      level_o = req_i.base;
    end else if (quot > {1'b0, req_i.cap}) begin
      level_o = req_i.cap;
    end else begin
      level_o = quot[LEVEL_BITS-1:0];
    end
  end

endmodule

[hw/rtl/idle_backlight_dimmer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_backlight_dimmer_top
// Idle backlight dimmer: tracks battery/mains normal, dim and blank modes
// from idle samples and emits a level and blank command on a mode change.
// ----------------------------------------------------------------------------
// A sample passes the input, request and output registers in turn before its result shows on m_axis.
// Throughput: one sample per cycle; the three stages (input register, mode
// stage, scaling multiplier into the output register) advance together and
// stall only while a result waits on m_axis_tready.
// Reset: mode, saved level and pipeline valids clear; registers take their
// reset values. No clearing pass is needed.
module idle_backlight_dimmer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [ibd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [ibd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // sample stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ibd_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // idle_ms, on_mains, current_level
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ibd_pkg::OUT_DATA_W-1:0] m_axis_tdata    // level_out, blank_display, new_mode
);
  import ibd_pkg::*;

  cfg_t                  cfg_q;
  logic                  adv;
  logic                  in_vld_q;
  logic [TIME_BITS-1:0]  idle_q;
  logic                  mains_q;
  logic [LEVEL_BITS-1:0] cur_q;
  scale_req_t            req, req_q;
  logic                  req_vld_q;
  logic [LEVEL_BITS-1:0] level;
  logic                  out_vld_q;
  logic [LEVEL_BITS-1:0] out_level_q;
  logic                  out_blank_q;
  mode_e                 out_mode_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_flags <= RST_MODE_FLAGS;
      cfg_q.bat_dim    <= RST_BAT_DIM;
      cfg_q.bat_off    <= RST_BAT_OFF;
      cfg_q.ac_dim     <= RST_AC_DIM;
      cfg_q.ac_off     <= RST_AC_OFF;
      cfg_q.bat_pcts   <= RST_BAT_PCTS;
      cfg_q.ac_pcts    <= RST_AC_PCTS;
      cfg_q.full_level <= RST_FULL_LEVEL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_MODE_FLAGS: cfg_q.mode_flags <= cfg_wdata_i[FLAG_BITS-1:0];
        CFG_BAT_DIM:    cfg_q.bat_dim    <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_BAT_OFF:    cfg_q.bat_off    <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_AC_DIM:     cfg_q.ac_dim     <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_AC_OFF:     cfg_q.ac_off     <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_BAT_PCTS:   cfg_q.bat_pcts   <= cfg_wdata_i[PCTS_BITS-1:0];
        CFG_AC_PCTS:    cfg_q.ac_pcts    <= cfg_wdata_i[PCTS_BITS-1:0];
        CFG_FULL_LEVEL: cfg_q.full_level <= cfg_wdata_i[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is held at the output
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      idle_q  <= s_axis_tdata[TIME_BITS-1:0];
      mains_q <= s_axis_tdata[TIME_BITS];
      cur_q   <= s_axis_tdata[TIME_BITS+1 +: LEVEL_BITS];
    end
  end

  // mode stage
  ibd_mode u_mode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (adv),
    .vld_i           (in_vld_q),
    .idle_ms_i       (idle_q),
    .on_mains_i      (mains_q),
    .current_level_i (cur_q),
    .cfg_i           (cfg_q),
    .req_o           (req)
  );

  // request register between mode stage and multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (adv) begin
      req_vld_q <= req.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && req.vld) begin
      req_q <= req;
    end
  end

  // scaling stage
  ibd_scale u_scale (
    .req_i   (req_q),
    .level_o (level)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && req_vld_q) begin
      out_level_q <= level;
      out_blank_q <= req_q.blank;
      out_mode_q  <= req_q.mode;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_mode_q, out_blank_q,
                          out_level_q};

endmodule

[hw/rtl/ibd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibd_checker
// Port-level checks of the idle backlight dimmer, bound to the top level.
// ----------------------------------------------------------------------------
module ibd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ibd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ibd_pkg::*;

  logic [2:0] last_mode_q;
  logic       have_last_q;
  logic [2:0] out_mode;
  logic       out_blank;

  assign out_mode  = m_axis_tdata[LEVEL_BITS+1 +: 3];
  assign out_blank = m_axis_tdata[LEVEL_BITS];

  // mode of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_last_q <= 1'b0;
      last_mode_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      have_last_q <= 1'b1;
      last_mode_q <= out_mode;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // blank goes with the off modes only
  a_blank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_blank == ((out_mode == MODE_BAT_OFF) ||
                                     (out_mode == MODE_AC_OFF))))
    else $error("blank does not match mode");

  // each result is a change from the previous one
  a_mode_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && have_last_q |-> out_mode != last_mode_q)
    else $error("result repeats the previous mode");

  // input side is open whenever no result waits
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

endmodule

bind idle_backlight_dimmer_top ibd_checker u_ibd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
